@@ hdl/madc_pkg.sv @@
// ----------------------------------------------------------------------------
// madc_pkg
// Shared types and constants for the mesh adjacency defect counter.
// ----------------------------------------------------------------------------
package madc_pkg;

    localparam int MAX_POINTS  = 1024;
    localparam int MAX_NBR     = 79;
    localparam int IDX_W       = 12;
    localparam int PT_W        = $clog2(MAX_POINTS);
    localparam int DEG_W       = 7;
    localparam int CFG_W       = 11;
    localparam int CNT_W       = 11;
    localparam int REGION_W    = 2;
    localparam int KIND_W      = 3;
    localparam int STORE_DEPTH = MAX_POINTS * MAX_NBR;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [REGION_W-1:0] REGION_INTERIOR = 2'd1;
    localparam logic [REGION_W-1:0] REGION_BAND     = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NONE  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FIVE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SEVEN = 3'd2;
    localparam logic [KIND_W-1:0] KIND_OTHER = 3'd3;
    localparam logic [KIND_W-1:0] KIND_BAND  = 3'd4;

    localparam logic OP_INSERT   = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    typedef struct packed {
        logic              deg_we;
        logic [PT_W-1:0]   deg_waddr;
        logic [DEG_W-1:0]  deg_wdata;
        logic [PT_W-1:0]   deg_raddr;
        logic              nbr_we;
        logic [ADDR_W-1:0] nbr_waddr;
        logic [IDX_W-1:0]  nbr_wdata;
        logic [ADDR_W-1:0] nbr_raddr;
    } mem_req_t;

    typedef struct packed {
        logic [CNT_W-1:0] edge_total;
        logic [CNT_W-1:0] defect_total;
        logic [CNT_W-1:0] five_total;
        logic [CNT_W-1:0] seven_total;
    } totals_t;

endpackage

@@ hdl/madc_mem.sv @@
// ----------------------------------------------------------------------------
// madc_mem
// Neighbour store and per-vertex degree memory, registered reads.
// ----------------------------------------------------------------------------
module madc_mem (
    input  logic                      aclk,
    input  madc_pkg::mem_req_t        req,
    output logic [madc_pkg::DEG_W-1:0] deg_rdata,
    output logic [madc_pkg::IDX_W-1:0] nbr_rdata
);
    import madc_pkg::*;

    logic [DEG_W-1:0] deg_mem [MAX_POINTS];
    logic [IDX_W-1:0] nbr_mem [STORE_DEPTH];

    always_ff @(posedge aclk) begin
        if (req.deg_we) begin
            deg_mem[req.deg_waddr] <= req.deg_wdata;
        end
        deg_rdata <= deg_mem[req.deg_raddr];
    end

    always_ff @(posedge aclk) begin
        if (req.nbr_we) begin
            nbr_mem[req.nbr_waddr] <= req.nbr_wdata;
        end
        nbr_rdata <= nbr_mem[req.nbr_raddr];
    end

endmodule

@@ hdl/madc_tally.sv @@
// ----------------------------------------------------------------------------
// madc_tally
// Defect classification by degree and region, saturating running counters.
// ----------------------------------------------------------------------------
module madc_tally (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          upd,
    input  logic [madc_pkg::DEG_W-1:0]    deg,
    input  logic [madc_pkg::REGION_W-1:0] region,
    output logic [madc_pkg::KIND_W-1:0]   kind,
    output madc_pkg::totals_t             totals
);
    import madc_pkg::*;

    totals_t tot_reg, tot_next;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    always_comb begin
        tot_next = tot_reg;
        kind     = KIND_NONE;
        if (region == REGION_BAND) begin
            kind = KIND_BAND;
            tot_next.edge_total = sat_inc(tot_reg.edge_total);
        end else if (region == REGION_INTERIOR && deg != DEG_W'(6)) begin
            tot_next.defect_total = sat_inc(tot_reg.defect_total);
            if (deg == DEG_W'(5)) begin
                kind = KIND_FIVE;
                tot_next.five_total = sat_inc(tot_reg.five_total);
            end else if (deg == DEG_W'(7)) begin
                kind = KIND_SEVEN;
                tot_next.seven_total = sat_inc(tot_reg.seven_total);
            end else begin
                kind = KIND_OTHER;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tot_reg <= '0;
        end else if (upd) begin
            tot_reg <= tot_next;
        end
    end

    assign totals = tot_reg;

endmodule

@@ hdl/madc_seq.sv @@
// ----------------------------------------------------------------------------
// madc_seq
// Sequencer: degree clear pass, six neighbour adds per triangle with a
// linear duplicate search, classify lookup, and the result word register.
// ----------------------------------------------------------------------------
module madc_seq (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [madc_pkg::CFG_W-1:0]    num_points,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          in_op,
    input  logic [madc_pkg::IDX_W-1:0]    in_vert_a,
    input  logic [madc_pkg::IDX_W-1:0]    in_vert_b,
    input  logic [madc_pkg::IDX_W-1:0]    in_vert_c,
    input  logic [madc_pkg::REGION_W-1:0] in_region,
    output madc_pkg::mem_req_t            mem_req,
    input  logic [madc_pkg::DEG_W-1:0]    deg_rdata,
    input  logic [madc_pkg::IDX_W-1:0]    nbr_rdata,
    output logic                          tally_upd,
    output logic [madc_pkg::DEG_W-1:0]    tally_deg,
    output logic [madc_pkg::REGION_W-1:0] tally_region,
    input  logic [madc_pkg::KIND_W-1:0]   tally_kind,
    input  madc_pkg::totals_t             totals,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          out_overflow,
    output logic [madc_pkg::DEG_W-1:0]    out_degree,
    output logic [madc_pkg::KIND_W-1:0]   out_kind,
    output madc_pkg::totals_t             out_totals
);
    import madc_pkg::*;

    typedef enum logic [8:0] {
        ST_CLEAR    = 9'b000000001,
        ST_IDLE     = 9'b000000010,
        ST_PAIR     = 9'b000000100,
        ST_DEG      = 9'b000001000,
        ST_SEARCH   = 9'b000010000,
        ST_ADD      = 9'b000100000,
        ST_CLS_RD   = 9'b001000000,
        ST_CLS_WAIT = 9'b010000000,
        ST_RESULT   = 9'b100000000
    } state_t;

    localparam int CMP_W = IDX_W + 1;
    localparam logic [2:0] PAIR_LAST = 3'd5;
    localparam logic [CFG_W-1:0] PT_LIMIT = CFG_W'(MAX_POINTS);

    state_t               state_reg, state_next;
    logic [PT_W-1:0]      clr_idx_reg, clr_idx_next;
    logic [IDX_W-1:0]     va_reg, va_next;
    logic [IDX_W-1:0]     vb_reg, vb_next;
    logic [IDX_W-1:0]     vc_reg, vc_next;
    logic [REGION_W-1:0]  region_reg, region_next;
    logic [2:0]           pair_reg, pair_next;
    logic [ADDR_W-1:0]    base_reg, base_next;
    logic [IDX_W-1:0]     nb_reg, nb_next;
    logic [PT_W-1:0]      v_reg, v_next;
    logic [DEG_W-1:0]     n_reg, n_next;
    logic [DEG_W-1:0]     k_reg, k_next;
    logic                 pend_reg, pend_next;
    logic                 ovf_reg, ovf_next;
    logic [DEG_W-1:0]     deg_res_reg, deg_res_next;
    logic [KIND_W-1:0]    kind_res_reg, kind_res_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 o_ovf_reg, o_ovf_next;
    logic [DEG_W-1:0]     o_deg_reg, o_deg_next;
    logic [KIND_W-1:0]    o_kind_reg, o_kind_next;
    totals_t              o_tot_reg, o_tot_next;

    logic [CFG_W-1:0]     lim;
    logic [IDX_W-1:0]     v_sel, nb_sel;
    logic                 v_sel_ok, va_ok;
    logic                 issue, hit, advance, out_free;

    assign lim = (num_points > PT_LIMIT) ? PT_LIMIT : num_points;

    // pair order: (a,b) (a,c) (b,a) (b,c) (c,a) (c,b)
    always_comb begin
        case (pair_reg)
            3'd0:    begin v_sel = va_reg; nb_sel = vb_reg; end
            3'd1:    begin v_sel = va_reg; nb_sel = vc_reg; end
            3'd2:    begin v_sel = vb_reg; nb_sel = va_reg; end
            3'd3:    begin v_sel = vb_reg; nb_sel = vc_reg; end
            3'd4:    begin v_sel = vc_reg; nb_sel = va_reg; end
            default: begin v_sel = vc_reg; nb_sel = vb_reg; end
        endcase
    end

    assign v_sel_ok = CMP_W'(v_sel)  < CMP_W'(lim);
    assign va_ok    = CMP_W'(va_reg) < CMP_W'(lim);
    assign issue    = k_reg < n_reg;
    assign hit      = pend_reg && (nbr_rdata == nb_reg);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        clr_idx_next  = clr_idx_reg;
        va_next       = va_reg;
        vb_next       = vb_reg;
        vc_next       = vc_reg;
        region_next   = region_reg;
        pair_next     = pair_reg;
        base_next     = base_reg;
        nb_next       = nb_reg;
        v_next        = v_reg;
        n_next        = n_reg;
        k_next        = k_reg;
        pend_next     = pend_reg;
        ovf_next      = ovf_reg;
        deg_res_next  = deg_res_reg;
        kind_res_next = kind_res_reg;
        o_ovf_next    = o_ovf_reg;
        o_deg_next    = o_deg_reg;
        o_kind_next   = o_kind_reg;
        o_tot_next    = o_tot_reg;
        m_valid_next  = m_ready ? 1'b0 : m_valid_reg;
        advance       = 1'b0;
        tally_upd     = 1'b0;

        mem_req           = '0;
        mem_req.deg_raddr = v_sel[PT_W-1:0];
        mem_req.nbr_raddr = base_reg + ADDR_W'(k_reg);
        mem_req.nbr_waddr = base_reg + ADDR_W'(n_reg);
        mem_req.nbr_wdata = nb_reg;
        mem_req.deg_waddr = v_reg;
        mem_req.deg_wdata = n_reg + 1'b1;

        case (state_reg)
            ST_CLEAR: begin
                mem_req.deg_we    = 1'b1;
                mem_req.deg_waddr = clr_idx_reg;
                mem_req.deg_wdata = '0;
                clr_idx_next      = clr_idx_reg + 1'b1;
                if (clr_idx_reg == {PT_W{1'b1}}) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    va_next       = in_vert_a;
                    vb_next       = in_vert_b;
                    vc_next       = in_vert_c;
                    region_next   = in_region;
                    pair_next     = '0;
                    ovf_next      = 1'b0;
                    deg_res_next  = '0;
                    kind_res_next = KIND_NONE;
                    state_next    = (in_op == OP_CLASSIFY) ? ST_CLS_RD : ST_PAIR;
                end
            end
            ST_PAIR: begin
                if (v_sel_ok) begin
                    v_next     = v_sel[PT_W-1:0];
                    nb_next    = nb_sel;
                    base_next  = ADDR_W'(v_sel[PT_W-1:0]) * ADDR_W'(MAX_NBR);
                    state_next = ST_DEG;
                end else begin
                    advance = 1'b1;
                end
            end
            ST_DEG: begin
                n_next     = deg_rdata;
                k_next     = '0;
                pend_next  = 1'b0;
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                k_next    = k_reg + DEG_W'(issue);
                pend_next = issue;
                if (hit) begin
                    advance = 1'b1;
                end else if (!issue && !pend_reg) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (n_reg >= DEG_W'(MAX_NBR)) begin
                    ovf_next = 1'b1;
                end else begin
                    mem_req.nbr_we = 1'b1;
                    mem_req.deg_we = 1'b1;
                end
                advance = 1'b1;
            end
            ST_CLS_RD: begin
                mem_req.deg_raddr = va_reg[PT_W-1:0];
                state_next        = va_ok ? ST_CLS_WAIT : ST_RESULT;
            end
            ST_CLS_WAIT: begin
                tally_upd     = 1'b1;
                deg_res_next  = deg_rdata;
                kind_res_next = tally_kind;
                state_next    = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    o_ovf_next   = ovf_reg;
                    o_deg_next   = deg_res_reg;
                    o_kind_next  = kind_res_reg;
                    o_tot_next   = totals;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (advance) begin
            if (pair_reg == PAIR_LAST) begin
                state_next = ST_RESULT;
            end else begin
                pair_next  = pair_reg + 1'b1;
                state_next = ST_PAIR;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
            m_valid_reg <= 1'b0;
            pair_reg    <= '0;
            pend_reg    <= 1'b0;
            ovf_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_idx_reg <= clr_idx_next;
            m_valid_reg <= m_valid_next;
            pair_reg    <= pair_next;
            pend_reg    <= pend_next;
            ovf_reg     <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        va_reg       <= va_next;
        vb_reg       <= vb_next;
        vc_reg       <= vc_next;
        region_reg   <= region_next;
        base_reg     <= base_next;
        nb_reg       <= nb_next;
        v_reg        <= v_next;
        n_reg        <= n_next;
        k_reg        <= k_next;
        deg_res_reg  <= deg_res_next;
        kind_res_reg <= kind_res_next;
        o_ovf_reg    <= o_ovf_next;
        o_deg_reg    <= o_deg_next;
        o_kind_reg   <= o_kind_next;
        o_tot_reg    <= o_tot_next;
    end

    assign s_ready      = (state_reg == ST_IDLE);
    assign tally_deg    = deg_rdata;
    assign tally_region = region_reg;
    assign m_valid      = m_valid_reg;
    assign out_overflow = o_ovf_reg;
    assign out_degree   = o_deg_reg;
    assign out_kind     = o_kind_reg;
    assign out_totals   = o_tot_reg;

endmodule

@@ hdl/mesh_adjacency_defect_counter_top.sv @@
// ----------------------------------------------------------------------------
// mesh_adjacency_defect_counter_top
// Builds per-vertex neighbour sets from triangles and classifies vertices
// by coordination number with running defect counters.
//
//   channel  dir  handshake          payload
//   s_       in   s_tvalid/s_tready  s_tdata vertices+region, s_tuser op
//   m_       out  m_tvalid/m_tready  m_tdata overflow, degree, kind, totals
//   cfg_     in   cfg_valid/ready    cfg_data num_points
//
// After reset the degree memory is cleared, with s_tready low. Insert: per
// vertex pair a degree read, a search with one store read a cycle that stops on
// a match, and an add unless the set is full; a pair whose vertex is past the
// limit is skipped; then the result. Classify: degree read and tally update
// unless past the limit, then the result. A waiting result stays in the output
// register while the next word is taken; the result step stalls on it.
// ----------------------------------------------------------------------------
module mesh_adjacency_defect_counter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // vert_a, vert_b, vert_c, region, zero pad
    input  logic        s_tuser,   // op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // overflow, degree, defect_kind, edge_total,
                                   // defect_total, five_total, seven_total, pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [10:0] cfg_data   // num_points
);
    import madc_pkg::*;

    logic [CFG_W-1:0]    num_points_reg;
    mem_req_t            mem_req;
    logic [DEG_W-1:0]    deg_rdata;
    logic [IDX_W-1:0]    nbr_rdata;
    logic                tally_upd;
    logic [DEG_W-1:0]    tally_deg;
    logic [REGION_W-1:0] tally_region;
    logic [KIND_W-1:0]   tally_kind;
    totals_t             totals;
    logic                out_overflow;
    logic [DEG_W-1:0]    out_degree;
    logic [KIND_W-1:0]   out_kind;
    totals_t             out_totals;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_points_reg <= CFG_W'(MAX_POINTS);
        end else if (cfg_valid) begin
            num_points_reg <= cfg_data;
        end
    end

    madc_mem u_mem (
        .aclk      (aclk),
        .req       (mem_req),
        .deg_rdata (deg_rdata),
        .nbr_rdata (nbr_rdata)
    );

    madc_tally u_tally (
        .aclk    (aclk),
        .aresetn (aresetn),
        .upd     (tally_upd),
        .deg     (tally_deg),
        .region  (tally_region),
        .kind    (tally_kind),
        .totals  (totals)
    );

    madc_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .num_points   (num_points_reg),
        .s_valid      (s_tvalid),
        .s_ready      (s_tready),
        .in_op        (s_tuser),
        .in_vert_a    (s_tdata[11:0]),
        .in_vert_b    (s_tdata[23:12]),
        .in_vert_c    (s_tdata[35:24]),
        .in_region    (s_tdata[37:36]),
        .mem_req      (mem_req),
        .deg_rdata    (deg_rdata),
        .nbr_rdata    (nbr_rdata),
        .tally_upd    (tally_upd),
        .tally_deg    (tally_deg),
        .tally_region (tally_region),
        .tally_kind   (tally_kind),
        .totals       (totals),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .out_overflow (out_overflow),
        .out_degree   (out_degree),
        .out_kind     (out_kind),
        .out_totals   (out_totals)
    );

    assign m_tdata = {1'b0,
                      out_totals.seven_total,
                      out_totals.five_total,
                      out_totals.defect_total,
                      out_totals.edge_total,
                      out_kind,
                      out_degree,
                      out_overflow};

endmodule

@@ test/madc_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// madc_result_checker
// Watches the triangle, result and point-limit channels of the mesh
// adjacency defect counter. Keeps its own neighbour sets, degree counts and
// running totals, predicts one result word per accepted input word and
// compares every result field against the oldest prediction.
// ----------------------------------------------------------------------------
module madc_result_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // vert_a, vert_b, vert_c, region, zero pad
    input  logic        s_tuser,   // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,   // overflow, degree, defect_kind, edge_total,
                                   // defect_total, five_total, seven_total, pad
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [10:0] cfg_data,  // num_points
    output int unsigned pending,
    output int unsigned errors
);
    import madc_pkg::*;

    localparam int DEG_HEX     = 6;
    localparam int DEG_FIVE    = 5;
    localparam int DEG_SEVEN   = 7;
    localparam int MAX_REPORTS = 64;

    typedef struct packed {
        logic              overflow;
        logic [DEG_W-1:0]  degree;
        logic [KIND_W-1:0] kind;
        logic [CNT_W-1:0]  edge_total;
        logic [CNT_W-1:0]  defect_total;
        logic [CNT_W-1:0]  five_total;
        logic [CNT_W-1:0]  seven_total;
    } mesh_result_t;

    logic [IDX_W-1:0] nbr_set [MAX_POINTS][MAX_NBR];
    logic [DEG_W-1:0] set_size [MAX_POINTS];
    logic [CNT_W-1:0] edge_cnt;
    logic [CNT_W-1:0] defect_cnt;
    logic [CNT_W-1:0] five_cnt;
    logic [CNT_W-1:0] seven_cnt;
    logic [CFG_W-1:0] num_points;
    mesh_result_t     result_q [$];
    int unsigned      err_count = 0;

    assign errors = err_count;

    function automatic logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
        return (c == CNT_MAX) ? c : c + 1'b1;
    endfunction

    // returns 1 when the add is dropped because the set is full
    function automatic logic link_vertex(int v, logic [IDX_W-1:0] nb);
        int  n;
        int  k;
        logic found;
        logic dropped;
        n = set_size[v];
        found = 1'b0;
        dropped = 1'b0;
        for (k = 0; k < n; k++) begin
            if (nbr_set[v][k] == nb) found = 1'b1;
        end
        if (!found) begin
            if (n >= MAX_NBR) begin
                dropped = 1'b1;
            end else begin
                nbr_set[v][n] = nb;
                set_size[v] = DEG_W'(n + 1);
            end
        end
        return dropped;
    endfunction

    function automatic mesh_result_t predict_result(logic op, logic [IDX_W-1:0] va,
                                                    logic [IDX_W-1:0] vb,
                                                    logic [IDX_W-1:0] vc,
                                                    logic [REGION_W-1:0] region);
        mesh_result_t r;
        int lim;
        r = '0;
        lim = (num_points < MAX_POINTS) ? int'(num_points) : MAX_POINTS;
        if (op == OP_INSERT) begin
            if (va < lim) begin
                r.overflow = r.overflow | link_vertex(va, vb);
                r.overflow = r.overflow | link_vertex(va, vc);
            end
            if (vb < lim) begin
                r.overflow = r.overflow | link_vertex(vb, va);
                r.overflow = r.overflow | link_vertex(vb, vc);
            end
            if (vc < lim) begin
                r.overflow = r.overflow | link_vertex(vc, va);
                r.overflow = r.overflow | link_vertex(vc, vb);
            end
        end else if (va < lim) begin
            r.degree = set_size[va];
            if (region == REGION_BAND) begin
                edge_cnt = bump(edge_cnt);
                r.kind = KIND_BAND;
            end else if (region == REGION_INTERIOR && r.degree != DEG_HEX) begin
                defect_cnt = bump(defect_cnt);
                if (r.degree == DEG_FIVE) begin
                    five_cnt = bump(five_cnt);
                    r.kind = KIND_FIVE;
                end else if (r.degree == DEG_SEVEN) begin
                    seven_cnt = bump(seven_cnt);
                    r.kind = KIND_SEVEN;
                end else begin
                    r.kind = KIND_OTHER;
                end
            end
        end
        r.edge_total   = edge_cnt;
        r.defect_total = defect_cnt;
        r.five_total   = five_cnt;
        r.seven_total  = seven_cnt;
        return r;
    endfunction

    task automatic compare_field(string name, int want, int got);
        if (want != got) begin
            if (err_count < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    always @(posedge aclk) begin : watch
        mesh_result_t want;
        mesh_result_t got;
        int i;
        if (!aresetn) begin
            for (i = 0; i < MAX_POINTS; i++) set_size[i] = '0;
            edge_cnt   = '0;
            defect_cnt = '0;
            five_cnt   = '0;
            seven_cnt  = '0;
            num_points = CFG_W'(MAX_POINTS);
            result_q.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.overflow     = m_tdata[0];
                got.degree       = m_tdata[7:1];
                got.kind         = m_tdata[10:8];
                got.edge_total   = m_tdata[21:11];
                got.defect_total = m_tdata[32:22];
                got.five_total   = m_tdata[43:33];
                got.seven_total  = m_tdata[54:44];
                if (result_q.size() == 0) begin
                    if (err_count < MAX_REPORTS)
                        $display("%0t: result word with nothing expected, expected none, got %h",
                                 $time, m_tdata);
                    err_count++;
                end else begin
                    want = result_q.pop_front();
                    compare_field("overflow", want.overflow, got.overflow);
                    compare_field("degree", want.degree, got.degree);
                    compare_field("defect_kind", want.kind, got.kind);
                    compare_field("edge_total", want.edge_total, got.edge_total);
                    compare_field("defect_total", want.defect_total, got.defect_total);
                    compare_field("five_total", want.five_total, got.five_total);
                    compare_field("seven_total", want.seven_total, got.seven_total);
                end
            end
            if (cfg_valid && cfg_ready) num_points = cfg_data;
            if (s_tvalid && s_tready)
                result_q.push_back(predict_result(s_tuser, s_tdata[11:0], s_tdata[23:12],
                                                  s_tdata[35:24], s_tdata[37:36]));
        end
        pending <= result_q.size();
    end

endmodule

@@ test/tb_mesh_adjacency_defect_counter_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mesh_adjacency_defect_counter_top
// Drives triangle and classify words into the mesh adjacency defect counter:
// directed fans of degree five, six and seven, self loops, out-of-range
// vertices and all region codes, then random fans, broken sequences and
// noise under several point limits, a full neighbour set and repeated
// counting of the same vertices. Both sides idle at random; the result
// checker does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_mesh_adjacency_defect_counter_top;
    import madc_pkg::*;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int LONG_HOLD   = 400;
    localparam int SPARE       = 1000;
    localparam int HUB         = 1002;
    localparam int FAN5        = 1005;
    localparam int SAT_FAN     = 1020;
    localparam int SAT_ROUNDS  = 10;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;   // vert_a, vert_b, vert_c, region, zero pad
    logic        s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // overflow, degree, defect_kind, edge_total,
                            // defect_total, five_total, seven_total, pad
    logic        cfg_valid;
    logic        cfg_ready;
    logic [10:0] cfg_data;  // num_points

    int unsigned pending;
    int unsigned errors;
    int          cycle_count = 0;
    int          sent_words  = 0;
    bit          fast_mode   = 1'b0;
    bit          hold_rx     = 1'b0;
    int          tx_left     = 0;
    int          rx_left     = 0;
    bit          tx_idle     = 1'b0;
    bit          rx_idle     = 1'b0;

    mesh_adjacency_defect_counter_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    madc_result_checker result_watch (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("tb_mesh_adjacency_defect_counter_top NOT OK");
        $finish;
    end

    // stretches of random gaps alternate with stretches of none
    task automatic draw_gap(inout int left, inout bit idle_mode, output int gap);
        if (left == 0) begin
            left = $urandom_range(1, 40);
            idle_mode = ($urandom_range(0, 3) != 0);
        end
        left--;
        gap = (idle_mode && !fast_mode) ? $urandom_range(0, 15) : 0;
    endtask

    initial begin : receiver
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            if (hold_rx) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                hold_rx = 1'b0;
            end
            draw_gap(rx_left, rx_idle, gap);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    task automatic send_word(logic op, int va, int vb, int vc, int region);
        int gap;
        draw_gap(tx_left, tx_idle, gap);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, REGION_W'(region), IDX_W'(vc), IDX_W'(vb), IDX_W'(va)};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        sent_words++;
    endtask

    task automatic insert_tri(int va, int vb, int vc);
        send_word(OP_INSERT, va, vb, vc, $urandom_range(0, 3));
    endtask

    task automatic classify(int v, int region);
        send_word(OP_CLASSIFY, v, $urandom_range(0, 4095), $urandom_range(0, 4095), region);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic set_points(int value);
        drain();
        cfg_data  <= CFG_W'(value);
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // full index range, keeping clear of the vertices set aside for directed use
    function automatic int any_vertex();
        int v;
        v = $urandom_range(0, 4095);
        if (v >= SPARE && v < MAX_POINTS) v = v - SPARE;
        return v;
    endfunction

    task automatic send_fan(int span);
        int centre;
        int k;
        int i;
        int ring[10];
        centre = $urandom_range(0, span - 1);
        k = $urandom_range(3, 9);
        for (i = 0; i < k; i++) ring[i] = $urandom_range(0, span - 1);
        for (i = 0; i < k; i++) begin
            case ($urandom_range(0, 2))
                0:       insert_tri(centre, ring[i], ring[(i + 1) % k]);
                1:       insert_tri(ring[i], ring[(i + 1) % k], centre);
                default: insert_tri(ring[(i + 1) % k], centre, ring[i]);
            endcase
        end
        classify(centre, $urandom_range(0, 1) ? int'(REGION_INTERIOR) : $urandom_range(0, 3));
        classify(ring[$urandom_range(0, k - 1)], $urandom_range(0, 3));
    endtask

    task automatic send_broken(int span);
        int centre;
        int other;
        int n;
        int i;
        centre = $urandom_range(0, span - 1);
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
            other = $urandom_range(0, span - 1);
            if ($urandom_range(0, 1)) insert_tri(centre, other, other);
            else insert_tri(other, centre, centre);
        end
        classify(centre, $urandom_range(0, 3));
    endtask

    task automatic run_phase(int count, int span);
        int stop_at;
        int pick;
        stop_at = sent_words + count;
        while (sent_words < stop_at) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                send_fan(span);
            end else if (pick < 8) begin
                send_word($urandom_range(0, 1) ? OP_CLASSIFY : OP_INSERT, any_vertex(),
                          any_vertex(), any_vertex(), $urandom_range(0, 3));
            end else begin
                send_broken(span);
            end
        end
    endtask

    initial begin : stimulus
        int i;
        int first_nb;
        int mid_limit;
        int sat_ring[5];
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= OP_INSERT;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // five-fold fan, then grow the centre to six and seven
        for (i = 0; i < 5; i++) insert_tri(FAN5, FAN5 + 5 + i, FAN5 + 5 + (i + 1) % 5);
        classify(FAN5, REGION_INTERIOR);
        insert_tri(FAN5, FAN5 + 5, FAN5 + 10);
        classify(FAN5, REGION_INTERIOR);
        insert_tri(FAN5 + 11, FAN5, FAN5 + 6);
        classify(FAN5, REGION_INTERIOR);
        classify(FAN5 + 5, REGION_BAND);
        classify(FAN5 + 5, 0);
        classify(FAN5 + 5, 3);
        classify(FAN5 + 5, REGION_INTERIOR);
        // self loops and vertices past the limit
        insert_tri(SPARE + 1, SPARE + 1, SPARE + 1);
        classify(SPARE + 1, REGION_INTERIOR);
        insert_tri(SPARE + 3, SPARE + 3, 4095);
        classify(4095, REGION_INTERIOR);
        insert_tri(0, 4095, 12'hAAA);
        send_word(OP_CLASSIFY, MAX_POINTS, 4095, 12'h555, REGION_BAND);
        classify(MAX_POINTS - 1, REGION_INTERIOR);
        classify(0, REGION_INTERIOR);

        set_points(2047);
        hold_rx = 1'b1;
        for (i = 0; i < 12; i++) classify($urandom_range(0, SPARE - 1), $urandom_range(0, 3));
        run_phase(60, SPARE);
        drain();
        run_phase(100, SPARE);

        set_points(1);
        run_phase(20, 4);
        set_points(0);
        run_phase(20, 4);
        mid_limit = $urandom_range(16, SPARE - 1);
        set_points(mid_limit);
        run_phase(60, (mid_limit + mid_limit / 4 < SPARE) ? mid_limit + mid_limit / 4 : SPARE);

        // fill one set past its capacity
        set_points(MAX_POINTS);
        first_nb = $urandom_range(0, SPARE - 1);
        insert_tri(HUB, first_nb, $urandom_range(0, SPARE - 1));
        for (i = 0; i < 49; i++)
            insert_tri(HUB, $urandom_range(0, SPARE - 1), $urandom_range(0, SPARE - 1));
        insert_tri(HUB, first_nb, first_nb);
        classify(HUB, REGION_INTERIOR);

        // count a five-fold, a seven-fold and a band vertex again and again
        sat_ring = '{SAT_FAN + 1, SAT_FAN + 2, SAT_FAN + 3, SAT_FAN - 3, SAT_FAN - 2};
        for (i = 0; i < 5; i++) insert_tri(SAT_FAN, sat_ring[i], sat_ring[(i + 1) % 5]);
        fast_mode = 1'b1;
        for (i = 0; i < SAT_ROUNDS; i++) begin
            classify(SAT_FAN, REGION_INTERIOR);
            classify(FAN5, REGION_INTERIOR);
            classify($urandom_range(0, SPARE - 1), REGION_BAND);
        end
        fast_mode = 1'b0;
        run_phase(20, SPARE);

        drain();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("tb_mesh_adjacency_defect_counter_top OK");
        end else begin
            $display("tb_mesh_adjacency_defect_counter_top NOT OK");
        end
        $finish;
    end

endmodule
